[design/bsv_pkg.sv]
// ----------------------------------------------------------------------------
// bsv_pkg: shared types and constants of the 3x3 box-sum core
// Holds the field widths of the streams, the result record and the defaults
// of the top-level parameters.
// ----------------------------------------------------------------------------
package bsv_pkg;

  // Field widths of the streams and of the configuration register.
  localparam int unsigned DigitW  = 4;
  localparam int unsigned SumW    = 7;
  localparam int unsigned OutRowW = 12;
  localparam int unsigned OutColW = 10;
  localparam int unsigned ColsW   = 11;
  localparam int unsigned ColSumW = 5;

  // Window geometry and digit range.
  localparam int unsigned WinSize  = 3;
  localparam int unsigned DigitMax = 9;

  // Defaults of the top-level parameters and the width after reset.
  localparam int unsigned MaxColsDef = 1024;
  localparam int unsigned MaxRowsDef = 4096;
  localparam int unsigned ColsReset  = 3;

  // Depth of the result queue; a power of two.
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  typedef logic [DigitW-1:0]  digit_t;
  typedef logic [ColSumW-1:0] colsum_t;

  // One result record as it travels through the queue.
  typedef struct packed {
    logic [SumW-1:0]    box_sum;
    logic [OutRowW-1:0] out_row;
    logic [OutColW-1:0] out_col;
    logic               row_end;
  } res_t;

endpackage

[design/bsv_in_if.sv]
// ----------------------------------------------------------------------------
// bsv_in_if: digit stream channel
// Valid/ready channel carrying one matrix element and its frame-start flag.
// ----------------------------------------------------------------------------
interface bsv_in_if;
  logic                       valid;
  logic                       ready;
  logic [bsv_pkg::DigitW-1:0] digit;
  logic                       frame_start;

  modport source (output valid, output digit, output frame_start, input ready);
  modport sink   (input valid, input digit, input frame_start, output ready);
endinterface

[design/bsv_out_if.sv]
// ----------------------------------------------------------------------------
// bsv_out_if: window-sum result channel
// Valid/ready channel carrying one window sum and its position.
// ----------------------------------------------------------------------------
interface bsv_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsv_pkg::SumW-1:0]    box_sum;
  logic [bsv_pkg::OutRowW-1:0] out_row;
  logic [bsv_pkg::OutColW-1:0] out_col;
  logic                        row_end;

  modport source (output valid, output box_sum, output out_row, output out_col,
                  output row_end, input ready);
  modport sink   (input valid, input box_sum, input out_row, input out_col,
                  input row_end, output ready);
endinterface

[design/bsv_win_cell.sv]
// ----------------------------------------------------------------------------
// bsv_win_cell: one column of the 3x3 window
// Holds one vertical column sum and takes its neighbour's value on each
// shift; a clear loads zero instead, as at the start of a frame.
// ----------------------------------------------------------------------------
module bsv_win_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          clr_i,
  input  logic [bsv_pkg::ColSumW-1:0]   data_i,
  output logic [bsv_pkg::ColSumW-1:0]   data_o
);
  import bsv_pkg::*;

  colsum_t sum_q, sum_d;

  // Shift in the neighbour's column sum, or zero on a clear.
  always_comb begin
    sum_d = sum_q;
    if (en_i) begin
      sum_d = clr_i ? '0 : data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign data_o = sum_q;

endmodule

[design/bsv_line_buf.sv]
// ----------------------------------------------------------------------------
// bsv_line_buf: paired line buffer memory
// Each entry holds the digits of the two rows above one column. The read is
// registered; a write to the address being read in the same cycle is
// forwarded so that the read returns the new pair.
// ----------------------------------------------------------------------------
module bsv_line_buf #(
  parameter int unsigned Depth = bsv_pkg::MaxColsDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [AddrW-1:0]              rd_addr_i,
  output logic [2*bsv_pkg::DigitW-1:0]  rd_data_o,
  input  logic                          wr_en_i,
  input  logic [AddrW-1:0]              wr_addr_i,
  input  logic [2*bsv_pkg::DigitW-1:0]  wr_data_i
);
  import bsv_pkg::*;

  localparam int unsigned PairW = 2 * DigitW;

  logic [PairW-1:0] mem [Depth];
  logic [PairW-1:0] rd_q;
  logic [PairW-1:0] byp_q;
  logic             byp_sel_q;

  // Memory array: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Forwarding of a write that collides with the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_sel_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_sel_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_q <= wr_data_i;
    end
  end

  assign rd_data_o = byp_sel_q ? byp_q : rd_q;

endmodule

[design/bsv_out_fifo.sv]
// ----------------------------------------------------------------------------
// bsv_out_fifo: result queue
// A small register queue in front of the result channel. It parts the
// result side from the input side and reports its fill level for the
// input credit check.
// ----------------------------------------------------------------------------
module bsv_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  bsv_pkg::res_t                 data_i,
  output logic [bsv_pkg::ResCntW-1:0]   count_o,
  bsv_out_if.source                     out_o
);
  import bsv_pkg::*;

  res_t               store_q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResCntW-1:0] count_q, count_d;
  logic               pop;
  res_t               head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = store_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + ResPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + ResPtrW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + ResCntW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage of the queued results.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  assign out_o.valid   = (count_q != '0);
  assign out_o.box_sum = head.box_sum;
  assign out_o.out_row = head.out_row;
  assign out_o.out_col = head.out_col;
  assign out_o.row_end = head.row_end;
  assign count_o       = count_q;

endmodule

[design/box_sum_3x3_valid_core.sv]
// ----------------------------------------------------------------------------
// box_sum_3x3_valid_core: 3x3 box-sum filter over the valid region
// Takes a raster stream of digits and gives the sum of every 3x3 window that
// lies wholly inside the matrix, with its row and column in the reduced
// matrix.
//
//   Channel   Direction  Payload                              Handshake
//   in_i      in         digit, frame_start                   valid/ready
//   out_o     out        box_sum, out_row, out_col, row_end   valid/ready
//   cfg       in         cfg_wdata_i (columns)                cfg_we_i
//
// One transaction is taken every cycle unless the input stalls; the line
// buffer memory is read and written once per element, which sets that
// figure. A result is offered after its element has passed the line buffer
// read and column sum, then the window sum and the queue write.
// Reset clears the counters, the window and the queue; the line buffers are
// not cleared. The input stalls only when the four-entry result queue plus
// the results still in flight would fill it.
// ----------------------------------------------------------------------------
module box_sum_3x3_valid_core #(
  parameter int unsigned MAX_COLS = bsv_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = bsv_pkg::MaxRowsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bsv_pkg::ColsW-1:0]   cfg_wdata_i,
  bsv_in_if.sink                      in_i,
  bsv_out_if.source                   out_o
);
  import bsv_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_COLS);
  localparam int unsigned RowW   = $clog2(MAX_ROWS);
  localparam int unsigned CmpW   = (CntW + 1 > ColsW) ? CntW + 1 : ColsW;
  localparam int unsigned PairW  = 2 * DigitW;
  localparam logic [RowW-1:0] RowMax = RowW'(MAX_ROWS - 1);

  // Configuration register.
  logic [ColsW-1:0] cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsW'(ColsReset);
    end else if (cfg_we_i) begin
      cols_q <= cfg_wdata_i;
    end
  end

  // Position counters and the decode of the element being taken.
  logic [CntW-1:0]  col_q, col_d, col_cur;
  logic [RowW-1:0]  row_q, row_d, row_cur;
  logic [CntW:0]    col_inc;
  logic             accept, last_col, emit0;
  digit_t           digit_sat;
  logic [ResCntW-1:0] fifo_cnt, credit;

  assign accept   = in_i.valid && in_i.ready;
  assign col_cur  = in_i.frame_start ? '0 : col_q;
  assign row_cur  = in_i.frame_start ? '0 : row_q;
  assign col_inc  = (CntW + 1)'(col_cur) + (CntW + 1)'(1);
  assign last_col = (CmpW'(col_inc) >= CmpW'(cols_q)) ||
                    (CmpW'(col_inc) >= CmpW'(MAX_COLS));
  assign emit0    = (cols_q >= ColsW'(WinSize)) &&
                    (col_cur >= CntW'(WinSize - 1)) &&
                    (row_cur >= RowW'(WinSize - 1));
  assign digit_sat = (in_i.digit > DigitW'(DigitMax)) ? DigitW'(DigitMax)
                                                      : in_i.digit;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      col_d = last_col ? '0 : CntW'(col_inc);
      row_d = (last_col && (row_cur != RowMax)) ? row_cur + RowW'(1) : row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input credit: queue fill plus results still in the pipeline.
  logic s1_valid_q, s1_emit_q, s2_emit_q;

  assign credit     = fifo_cnt + ResCntW'(s1_emit_q) + ResCntW'(s2_emit_q);
  assign in_i.ready = (credit < ResCntW'(ResDepth));

  // First stage: wait for the line buffer read.
  logic [CntW-1:0]    s1_addr_q;
  digit_t             s1_digit_q;
  logic               s1_fs_q;
  logic [OutRowW-1:0] s1_row_q;
  logic [OutColW-1:0] s1_col_q;
  logic               s1_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_emit_q  <= accept && emit0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q  <= col_cur;
      s1_digit_q <= digit_sat;
      s1_fs_q    <= in_i.frame_start;
      s1_row_q   <= OutRowW'(32'(row_cur) - 32'(WinSize - 1));
      s1_col_q   <= OutColW'(32'(col_cur) - 32'(WinSize - 1));
      s1_end_q   <= last_col;
    end
  end

  // Line buffers: upper digit in the high half, middle digit in the low half.
  logic [PairW-1:0] lb_rd_data, lb_wr_data;
  digit_t           lb_upper, lb_middle;
  logic [DigitW+1:0] colsum_full;
  colsum_t          colsum;

  assign lb_upper    = lb_rd_data[PairW-1:DigitW];
  assign lb_middle   = lb_rd_data[DigitW-1:0];
  assign lb_wr_data  = {lb_middle, s1_digit_q};
  assign colsum_full = (DigitW + 2)'(lb_upper) + (DigitW + 2)'(lb_middle) +
                       (DigitW + 2)'(s1_digit_q);
  assign colsum      = colsum_full[ColSumW-1:0];

  bsv_line_buf #(
    .Depth (MAX_COLS),
    .AddrW (CntW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_cur),
    .rd_data_o (lb_rd_data),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (lb_wr_data)
  );

  // Window: a chain of column cells, the newest column sum entering at the end.
  colsum_t win [WinSize];

  for (genvar i = 0; i < WinSize; i++) begin : g_win
    if (i == WinSize - 1) begin : g_last
      bsv_win_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (s1_valid_q),
        .clr_i  (1'b0),
        .data_i (colsum),
        .data_o (win[i])
      );
    end else begin : g_mid
      bsv_win_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (s1_valid_q),
        .clr_i  (s1_fs_q),
        .data_i (win[i+1]),
        .data_o (win[i])
      );
    end
  end

  // Second stage: sum the shifted window and queue the result.
  logic [OutRowW-1:0] s2_row_q;
  logic [OutColW-1:0] s2_col_q;
  logic               s2_end_q;
  logic [SumW-1:0]    win_sum;
  res_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_emit_q <= 1'b0;
    end else begin
      s2_emit_q <= s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_row_q <= s1_row_q;
      s2_col_q <= s1_col_q;
      s2_end_q <= s1_end_q;
    end
  end

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < WinSize; i++) begin
      win_sum = win_sum + SumW'(win[i]);
    end
  end

  assign res.box_sum = win_sum;
  assign res.out_row = s2_row_q;
  assign res.out_col = s2_col_q;
  assign res.row_end = s2_end_q;

  bsv_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_emit_q),
    .data_i  (res),
    .count_o (fifo_cnt),
    .out_o   (out_o)
  );

  // A result is never pushed into a full queue.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_emit_q |-> (fifo_cnt < ResCntW'(ResDepth)))
    else $error("result pushed into a full queue");

  // A frame start puts the next element in column one when rows are wide.
  a_frame_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.frame_start && (cols_q >= ColsW'(WinSize - 1)))
      |=> (col_q == CntW'(1)))
    else $error("column counter not restarted by frame start");

  // The row counter holds at its bound.
  a_row_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.frame_start && (row_q == RowMax)) |=> (row_q == RowMax))
    else $error("row counter left its bound");

  // An emitting element has passed its line buffer read in the previous cycle.
  a_emit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_emit_q |-> $past(s1_valid_q))
    else $error("result without a processed element");

endmodule
